@@ sv/ble_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg: shared types and constants for the bully leader election core
// event codes, result kinds, protocol states and the per-event plan struct
// ----------------------------------------------------------------------------
package ble_pkg;

    // peer list limits
    localparam int MAX_PEERS = 8;
    localparam logic [3:0] ELECT_CAP = (MAX_PEERS < 8) ? 4'(MAX_PEERS) : 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_MY_PRIORITY  = 2'd0;
    localparam logic [1:0] CFG_SELF_MAC     = 2'd1;
    localparam logic [1:0] CFG_OK_WAIT      = 2'd2;
    localparam logic [1:0] CFG_COORD_WAIT   = 2'd3;

    localparam logic [15:0] OK_WAIT_RESET    = 16'd1000;
    localparam logic [15:0] COORD_WAIT_RESET = 16'd2000;

    // event codes
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_HB_TIMEOUT = 3'd1;
    localparam logic [2:0] ACT_ELECTION  = 3'd2;
    localparam logic [2:0] ACT_OK        = 3'd3;
    localparam logic [2:0] ACT_COORD     = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_STATUS   = 3'd0;
    localparam logic [2:0] KIND_ELECTION = 3'd1;
    localparam logic [2:0] KIND_OK       = 3'd2;
    localparam logic [2:0] KIND_ANNOUNCE = 3'd3;
    localparam logic [2:0] KIND_ADOPT    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE        = 2'd0,
        ST_WAIT_OK     = 2'd1,
        ST_IN_ELECTION = 2'd2,
        ST_COORD       = 2'd3
    } t_node;

    // everything one event decides, held while its results go out
    typedef struct packed {
        t_node       next_state;
        logic        cd_run;
        logic [15:0] cd;
        logic        has_ok;
        logic [47:0] ok_mac;
        logic [3:0]  n_elect;
        logic        has_lead;
        logic [2:0]  lead_kind;
        logic [47:0] lead_mac;
        logic [31:0] lead_prio;
    } t_plan;

endpackage

@@ sv/bully_leader_election_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bully_leader_election_core: bully leader election node
// takes one event word, updates the protocol state and streams its results
// ----------------------------------------------------------------------------
// One event word (tick, heartbeat timeout, or a received election, ok or
// coordinator message) is taken while the core is idle. The cycle after
// acceptance the decision unit updates the protocol state and the shared
// countdown and fixes the result list; then the output register sends the
// results one per cycle while the receiver is ready: an ok reply if the sender
// ranks below us, one election send per higher peer (at most eight) or a self
// announcement, an adopted-leader report for a coordinator message, and always
// a closing status word with tlast. Every result carries the state reached
// after the event. An event has 1 to 10 results. A new event is taken as soon
// as the closing status is loaded, even while it waits.
// Configuration writes are always accepted and are meant for idle periods.
// ----------------------------------------------------------------------------
module bully_leader_election_core import ble_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // event stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // src_mac[47:0], sender_priority[79:48], higher_peer_count[83:80], zero pad
    input  logic [87:0]  i_s_axis_tdata,
    // action[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // peer_index[2:0], dest_mac[50:3], leader_mac[98:51],
    // leader_priority[130:99], node_state[132:131], zero pad
    output logic [135:0] o_m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PLAN = 3'b010,
        S_EMIT = 3'b100
    } t_fsm;

    // control
    t_fsm        r_fsm, n_fsm;
    t_node       r_state;
    logic        r_cd_run;
    logic [15:0] r_cd;
    logic [3:0]  r_step;
    logic        r_out_valid;

    // config
    logic [31:0] r_my_priority;
    logic [47:0] r_self_mac;
    logic [15:0] r_ok_wait;
    logic [15:0] r_coord_wait;

    // captured event and plan
    logic [2:0]  r_action;
    logic [47:0] r_src_mac;
    logic [31:0] r_sender_priority;
    logic [3:0]  r_peers;
    t_plan       r_plan;
    t_plan       w_plan;

    // output word
    logic [2:0]  r_kind;
    logic [2:0]  r_peer_index;
    logic [47:0] r_dest_mac;
    logic [47:0] r_leader_mac;
    logic [31:0] r_leader_prio;
    t_node       r_out_state;
    logic        r_last;

    logic        in_acc;
    logic        out_acc;
    logic        load_out;
    logic [3:0]  total;
    logic [3:0]  j0;
    logic [3:0]  j1;
    logic [2:0]  n_kind;
    logic [2:0]  n_peer_index;
    logic [47:0] n_dest_mac;
    logic [47:0] n_leader_mac;
    logic [31:0] n_leader_prio;
    logic        n_last;

    assign o_s_axis_tready = (r_fsm == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = r_out_valid && i_m_axis_tready;

    ble_decide u_decide (
        .i_state             (r_state),
        .i_cd_run            (r_cd_run),
        .i_cd                (r_cd),
        .i_action            (r_action),
        .i_src_mac           (r_src_mac),
        .i_sender_priority   (r_sender_priority),
        .i_higher_peer_count (r_peers),
        .i_my_priority       (r_my_priority),
        .i_self_mac          (r_self_mac),
        .i_ok_wait           (r_ok_wait),
        .i_coord_wait        (r_coord_wait),
        .o_plan              (w_plan)
    );

    // result count: ok + elections + leader + status
    assign total = {3'b0, r_plan.has_ok} + r_plan.n_elect
                 + {3'b0, r_plan.has_lead} + 4'd1;

    assign load_out = (r_fsm == S_EMIT) && (!r_out_valid || out_acc);

    // pick the result for the current step
    always_comb begin
        n_kind        = KIND_STATUS;
        n_peer_index  = '0;
        n_dest_mac    = '0;
        n_leader_mac  = '0;
        n_leader_prio = '0;
        j0            = r_step - {3'b0, r_plan.has_ok};
        j1            = j0 - r_plan.n_elect;
        n_last        = (r_step == total - 4'd1);
        if (r_plan.has_ok && r_step == 4'd0) begin
            n_kind     = KIND_OK;
            n_dest_mac = r_plan.ok_mac;
        end else if (j0 < r_plan.n_elect) begin
            n_kind       = KIND_ELECTION;
            n_peer_index = j0[2:0];
        end else if (r_plan.has_lead && j1 == 4'd0) begin
            n_kind        = r_plan.lead_kind;
            n_leader_mac  = r_plan.lead_mac;
            n_leader_prio = r_plan.lead_prio;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE: if (in_acc) n_fsm = S_PLAN;
            S_PLAN: n_fsm = S_EMIT;
            S_EMIT: if (load_out && n_last) n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= ST_IDLE;
            r_cd_run    <= 1'b0;
            r_cd        <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (r_fsm == S_PLAN) begin
                r_state  <= w_plan.next_state;
                r_cd_run <= w_plan.cd_run;
                r_cd     <= w_plan.cd;
                r_step   <= '0;
            end else if (load_out) begin
                r_step <= r_step + 4'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_priority <= '0;
            r_self_mac    <= '0;
            r_ok_wait     <= OK_WAIT_RESET;
            r_coord_wait  <= COORD_WAIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MY_PRIORITY: r_my_priority <= i_cfg_data[31:0];
                CFG_SELF_MAC:    r_self_mac    <= i_cfg_data;
                CFG_OK_WAIT:     r_ok_wait     <= i_cfg_data[15:0];
                CFG_COORD_WAIT:  r_coord_wait  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action          <= i_s_axis_tuser;
            r_src_mac         <= i_s_axis_tdata[47:0];
            r_sender_priority <= i_s_axis_tdata[79:48];
            r_peers           <= i_s_axis_tdata[83:80];
        end
        if (r_fsm == S_PLAN) begin
            r_plan <= w_plan;
        end
        if (load_out) begin
            r_kind        <= n_kind;
            r_peer_index  <= n_peer_index;
            r_dest_mac    <= n_dest_mac;
            r_leader_mac  <= n_leader_mac;
            r_leader_prio <= n_leader_prio;
            // state is held with the word, the next event may be planned
            // while the closing word still waits
            r_out_state   <= r_state;
            r_last        <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tdata  = {3'b000, r_out_state, r_leader_prio, r_leader_mac,
                              r_dest_mac, r_peer_index};

    // the closing word of a run is always a status word
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser == KIND_STATUS)
        else $error("closing word is not a status word");

    // an accepted event moves straight to the planning cycle
    a_accept_plans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_fsm == S_PLAN)
        else $error("accepted event not planned");

    // a word still waiting while idle must be the closing one
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_fsm == S_IDLE |-> o_m_axis_tlast)
        else $error("idle with a run still open");

    // sequencer stays one-hot
    a_fsm_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_fsm))
        else $error("sequencer state not one-hot");

endmodule

@@ sv/ble_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_decide: event decision unit
// one compare and countdown step per event, yields the state update and the
// list of results to send
// ----------------------------------------------------------------------------
module ble_decide import ble_pkg::*; (
    input  t_node       i_state,
    input  logic        i_cd_run,
    input  logic [15:0] i_cd,
    input  logic [2:0]  i_action,
    input  logic [47:0] i_src_mac,
    input  logic [31:0] i_sender_priority,
    input  logic [3:0]  i_higher_peer_count,
    input  logic [31:0] i_my_priority,
    input  logic [47:0] i_self_mac,
    input  logic [15:0] i_ok_wait,
    input  logic [15:0] i_coord_wait,
    output t_plan       o_plan
);

    logic       do_elect;
    logic       do_coord;
    logic [3:0] n_cap;

    assign n_cap = (i_higher_peer_count < ELECT_CAP) ? i_higher_peer_count : ELECT_CAP;

    always_comb begin
        o_plan            = '0;
        o_plan.next_state = i_state;
        o_plan.cd_run     = i_cd_run;
        o_plan.cd         = i_cd;
        o_plan.ok_mac     = i_src_mac;
        do_elect          = 1'b0;
        do_coord          = 1'b0;

        case (i_action)
            ACT_TICK: begin
                if (i_cd_run) begin
                    if (i_cd <= 16'd1) begin
                        o_plan.cd     = '0;
                        o_plan.cd_run = 1'b0;
                        if (i_state == ST_WAIT_OK) begin
                            do_coord = 1'b1;
                        end else if (i_state == ST_IN_ELECTION) begin
                            do_elect = 1'b1;
                        end
                    end else begin
                        o_plan.cd = i_cd - 16'd1;
                    end
                end
            end
            ACT_HB_TIMEOUT: begin
                do_elect = 1'b1;
            end
            ACT_ELECTION: begin
                if (i_sender_priority < i_my_priority) begin
                    o_plan.has_ok = 1'b1;
                    do_elect      = 1'b1;
                end
            end
            ACT_OK: begin
                if (i_state == ST_WAIT_OK) begin
                    o_plan.next_state = ST_IN_ELECTION;
                    o_plan.cd_run     = 1'b1;
                    o_plan.cd         = i_coord_wait;
                end
            end
            ACT_COORD: begin
                o_plan.cd_run     = 1'b0;
                o_plan.cd         = '0;
                o_plan.next_state = ST_IDLE;
                o_plan.has_lead   = 1'b1;
                o_plan.lead_kind  = KIND_ADOPT;
                o_plan.lead_mac   = i_src_mac;
                o_plan.lead_prio  = i_sender_priority;
            end
            default: begin
            end
        endcase

        // election start, no effect while already coordinator
        if (do_elect && i_state != ST_COORD) begin
            if (n_cap == 4'd0) begin
                do_coord = 1'b1;
            end else begin
                o_plan.n_elect    = n_cap;
                o_plan.next_state = ST_WAIT_OK;
                o_plan.cd_run     = 1'b1;
                o_plan.cd         = i_ok_wait;
            end
        end

        if (do_coord) begin
            o_plan.next_state = ST_COORD;
            o_plan.cd_run     = 1'b0;
            o_plan.cd         = '0;
            o_plan.has_lead   = 1'b1;
            o_plan.lead_kind  = KIND_ANNOUNCE;
            o_plan.lead_mac   = i_self_mac;
            o_plan.lead_prio  = i_my_priority;
        end
    end

endmodule
